@@ hw/rtl/wpm_pkg.sv @@
// Shared types and constants for the waypoint motion player.
// No dependencies; imported by every module of the block.
`default_nettype none

package wpm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // One waypoint table entry.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        ticks;
    logic               ends_block;
  } point_t;

  // Request into the shared divider.
  typedef struct packed {
    logic               start;
    logic signed [32:0] dividend;
    logic [15:0]        divisor;
  } div_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/wpm_table.sv @@
// Waypoint table: single write port, one registered read port.
// Depends on wpm_pkg for the entry type and depth.
`default_nettype none

module wpm_table (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [wpm_pkg::IDX_W-1:0] waddr,
  input  wire wpm_pkg::point_t          wdata,
  input  wire logic [wpm_pkg::IDX_W-1:0] raddr,
  output wpm_pkg::point_t               rdata
);
  import wpm_pkg::*;

  point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/wpm_div.sv @@
// Radix-2 restoring divider, signed 33-bit by unsigned 16-bit, one bit a cycle.
// Quotient truncates toward zero and saturates to 32 bits. Depends on wpm_pkg.
`default_nettype none

module wpm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wpm_pkg::div_req_t req,
  output logic                   done,
  output logic signed [31:0]     quo
);
  import wpm_pkg::*;

  localparam int STEPS = 33;
  localparam int CW    = $clog2(STEPS + 1);

  logic [15:0]   rem;
  logic [32:0]   work;
  logic [15:0]   dvs;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          busy;

  logic [16:0]   trial;
  logic          ge;
  logic [15:0]   rem_next;
  logic [32:0]   work_next;
  logic [32:0]   neg_q;

  always_comb begin
    trial     = {rem, work[32]};
    ge        = trial >= {1'b0, dvs};
    rem_next  = ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
    work_next = {work[31:0], ge};
    neg_q     = -work_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= req.dividend[32];
        work <= req.dividend[32] ? 33'(-req.dividend) : req.dividend;
      end else if (busy) begin
        rem  <= rem_next;
        work <= work_next;
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) begin
            quo <= (work_next[32] | work_next[31]) ? 32'sh7FFF_FFFF
                                                   : $signed(work_next[31:0]);
          end else begin
            quo <= (work_next > 33'h0_8000_0000) ? 32'sh8000_0000
                                                 : $signed(neg_q[31:0]);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/waypoint_motion_player.sv @@
// Waypoint motion player: steps a Q16.16 position along a waypoint table, one request a tick.
// Append, clear and restart complete while idle. A tick holds position when finished or empty;
// else it takes the first waypoint or steps by velocity; at a segment end it snaps to the target
// and sets up the next segment, zero velocity if zero-length, else the shared divider runs 33
// steps for x, then 33 for y. One request at a time; in_ready only while idle.
// Reset (rst, synchronous): table empty, playback and position/velocity cleared, no result held.
`default_nettype none

module waypoint_motion_player (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] way_x,
  input  wire logic signed [31:0] way_y,
  input  wire logic [15:0]        way_ticks,
  input  wire logic               ends_block,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic                    done_res,
  output logic                    block_event,
  output logic [6:0]              block_number
);
  import wpm_pkg::*;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] S_LOAD0 = 3'd1;  // entry 0 arrives: take first waypoint
  localparam logic [2:0] S_ADV   = 3'd2;  // step by velocity, check segment end
  localparam logic [2:0] S_RDC   = 3'd3;  // entry c arrives: snap to target
  localparam logic [2:0] S_RDN   = 3'd4;  // entry n arrives: set up next segment
  localparam logic [2:0] S_DIVX  = 3'd5;  // x velocity division running
  localparam logic [2:0] S_DIVY  = 3'd6;  // y velocity division running
  localparam logic [2:0] S_FIN   = 3'd7;  // hand result to output register

  logic [2:0]         state;
  logic [CNT_W-1:0]   point_count;
  logic [IDX_W-1:0]   current_index;
  logic [16:0]        phase_count;
  logic [15:0]        segment_ticks;
  logic signed [31:0] px, py, vx, vy;
  logic [6:0]         block_index;
  logic               finished_flag;
  logic               ev;           // block event of the tick in flight
  logic               end_mark;     // ends_block of the waypoint just reached
  logic signed [31:0] target_y;

  // table
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_raddr;
  point_t             tbl_wdata;
  point_t             tbl_rdata;

  // shared divider
  div_req_t           dreq;
  logic               ddone;
  logic signed [31:0] dquo;

  logic               acc;
  logic [CNT_W-1:0]   idx_ext;
  logic [CNT_W-1:0]   idx_inc;
  logic [16:0]        phase_inc;
  logic signed [32:0] sum_x, sum_y;
  logic signed [31:0] sat_x, sat_y;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign idx_ext   = {1'b0, current_index};
  assign idx_inc   = idx_ext + 1'b1;
  assign phase_inc = phase_count + 1'b1;

  // Saturating position step
  always_comb begin
    sum_x = {px[31], px} + {vx[31], vx};
    sum_y = {py[31], py} + {vy[31], vy};
    sat_x = (sum_x[32] != sum_x[31]) ? (sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                     : sum_x[31:0];
    sat_y = (sum_y[32] != sum_y[31]) ? (sum_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                     : sum_y[31:0];
  end

  // Append writes at the fill point; reads follow the sequencer.
  assign tbl_we    = acc && (kind == KIND_APPEND) && (point_count < CNT_W'(MAX_POINTS));
  assign tbl_wdata = '{x: way_x, y: way_y, ticks: way_ticks, ends_block: ends_block};

  always_comb begin
    unique case (state)
      S_ADV:   tbl_raddr = current_index;
      S_RDC:   tbl_raddr = idx_inc[IDX_W-1:0];
      default: tbl_raddr = '0;
    endcase
  end

  wpm_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Divider start: x difference on segment setup, y difference once x is back.
  always_comb begin
    dreq.start    = 1'b0;
    dreq.divisor  = segment_ticks;
    dreq.dividend = {target_y[31], target_y} - {py[31], py};
    if (state == S_RDN && tbl_rdata.ticks != 16'd0) begin
      dreq.start    = 1'b1;
      dreq.divisor  = tbl_rdata.ticks;
      dreq.dividend = {tbl_rdata.x[31], tbl_rdata.x} - {px[31], px};
    end else if (state == S_DIVX && ddone) begin
      dreq.start    = 1'b1;
    end
  end

  wpm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= '0;
      current_index <= '0;
      phase_count   <= '0;
      segment_ticks <= '0;
      px            <= '0;
      py            <= '0;
      vx            <= '0;
      vy            <= '0;
      block_index   <= '0;
      finished_flag <= 1'b0;
      ev            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // S_FIN loads the output register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (kind)
              KIND_APPEND: begin
                if (tbl_we) begin
                  point_count <= point_count + 1'b1;
                end
              end
              KIND_CLEAR, KIND_RESTART: begin
                if (kind == KIND_CLEAR) begin
                  point_count <= '0;
                end
                finished_flag <= 1'b0;
                current_index <= '0;
                phase_count   <= '0;
                segment_ticks <= '0;
                block_index   <= '0;
              end
              KIND_TICK: begin
                ev <= 1'b0;
                priority if (finished_flag || point_count == '0) begin
                  state <= S_FIN;           // hold position
                end else if (phase_count == '0 && current_index == '0) begin
                  state <= S_LOAD0;         // entry 0 read is in flight
                end else begin
                  state <= S_ADV;
                end
              end
              default: ;
            endcase
          end
        end

        S_LOAD0: begin
          px            <= tbl_rdata.x;
          py            <= tbl_rdata.y;
          segment_ticks <= tbl_rdata.ticks;
          phase_count   <= 17'd1;
          vx            <= '0;
          vy            <= '0;
          // zero hold time falls through into the first segment
          state         <= (tbl_rdata.ticks == 16'd0) ? S_ADV : S_FIN;
        end

        S_ADV: begin
          px          <= sat_x;
          py          <= sat_y;
          phase_count <= phase_inc;
          if (phase_inc >= {1'b0, segment_ticks}) begin
            if (idx_ext >= point_count) begin
              finished_flag <= 1'b1;
              state         <= S_FIN;
            end else begin
              phase_count <= '0;
              state       <= S_RDC;       // entry c read is in flight
            end
          end else begin
            state <= S_FIN;
          end
        end

        S_RDC: begin
          px       <= tbl_rdata.x;        // snap exactly to target
          py       <= tbl_rdata.y;
          end_mark <= tbl_rdata.ends_block;
          if (idx_inc < point_count) begin
            state <= S_RDN;
          end else begin
            finished_flag <= 1'b1;        // last waypoint reached
            state         <= S_FIN;
          end
        end

        S_RDN: begin
          current_index <= idx_inc[IDX_W-1:0];
          segment_ticks <= tbl_rdata.ticks;
          target_y      <= tbl_rdata.y;
          if (end_mark) begin
            block_index <= block_index + 1'b1;
            ev          <= 1'b1;
          end
          if (tbl_rdata.ticks == 16'd0) begin
            vx    <= '0;
            vy    <= '0;
            state <= S_FIN;
          end else begin
            state <= S_DIVX;
          end
        end

        S_DIVX: begin
          if (ddone) begin
            vx    <= dquo;
            state <= S_DIVY;
          end
        end

        S_DIVY: begin
          if (ddone) begin
            vy    <= dquo;
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            pos_x        <= px;
            pos_y        <= py;
            done_res     <= finished_flag;
            block_event  <= ev;
            block_number <= ev ? block_index : 7'd0;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
